// ----- rtl/sroc_pkg.sv -----
`timescale 1ns / 1ps

package sroc_pkg;

  localparam int COORD_W = 10;
  localparam int TALLY_W = 21;
  localparam int HITS_W  = 2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [HITS_W-1:0]  HIT_LIMIT = HITS_W'(2);

  // queue between the classifier and the walker
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } step_dir_t;

  typedef struct packed {
    logic               skip;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    step_dir_t          dir_x;
    step_dir_t          dir_y;
    logic [COORD_W-1:0] span;   // cells to walk minus one
  } walk_cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOAD,
    B_WALK,
    B_DRAIN,
    B_REPORT
  } back_state_t;

endpackage

// ----- rtl/sroc_ifs.sv -----
`timescale 1ns / 1ps

interface sroc_in_if import sroc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sroc_out_if import sroc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TALLY_W-1:0] overlap_total;
  logic               segment_skipped;

  modport source (output valid, overlap_total, segment_skipped, input ready);
  modport sink   (input valid, overlap_total, segment_skipped, output ready);
endinterface

interface sroc_cfg_if;
  logic valid;
  logic ready;
  logic diagonals_enabled;

  modport source (output valid, diagonals_enabled, input ready);
  modport sink   (input valid, diagonals_enabled, output ready);
endinterface

// ----- rtl/segment_raster_overlap_counter_unit.sv -----
`timescale 1ns / 1ps

// Segment raster overlap counter. Each word on seg_in is one line segment
// (two end points on a GRID_SIDE x GRID_SIDE grid); the unit bumps a 2-bit
// saturating hit count for every cell the segment covers, ends included,
// for horizontal, vertical and (when diagonals_enabled is set) exact
// 45-degree segments, and returns one word on res_out per segment: the
// running number of cells hit at least twice, plus a skip flag for any
// segment that is off the grid or has another slope. After reset the grid
// store is swept to zero, one cell per cycle, with seg_in.ready held low;
// cfg writes are taken throughout. The walker handles one segment at a
// time, its pace bounded by the single read-modify-write port pair of the
// grid store. A two-word queue sits between the classifier and the walker,
// and a result register between the walker and res_out, so a stall on
// either side is absorbed until the queue or the result register fills.
module segment_raster_overlap_counter_unit import sroc_pkg::*; #(
  parameter int GRID_SIDE = 1024
) (
  input  logic       clk,
  input  logic       rst,
  sroc_cfg_if.sink   cfg,
  sroc_in_if.sink    seg_in,
  sroc_out_if.source res_out
);

  logic      diag_en;
  logic      clearing;
  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  walk_cmd_t push_cmd;
  walk_cmd_t q_head;

  // config register; always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_en <= 1'b1;
    end else if (cfg.valid) begin
      diag_en <= cfg.diagonals_enabled;
    end
  end

  // classifier: turns end points into a walk command
  sroc_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .seg_in   (seg_in),
    .diag_en  (diag_en),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  sroc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // walker: grid store, hit counts, tally and result register
  sroc_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .res_out  (res_out)
  );

endmodule

// ----- rtl/sroc_front.sv -----
`timescale 1ns / 1ps

module sroc_front import sroc_pkg::*; #(
  parameter int GRID_SIDE = 1024
) (
  sroc_in_if.sink   seg_in,
  input  logic      diag_en,
  input  logic      clearing,
  input  logic      q_full,
  output logic      push,
  output walk_cmd_t cmd
);

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               off_grid;
  logic               axis;
  logic               diag;

  assign seg_in.ready = !q_full && !clearing;
  assign push         = seg_in.valid && seg_in.ready;

  always_comb begin
    dx = (seg_in.start_x > seg_in.end_x) ? seg_in.start_x - seg_in.end_x
                                         : seg_in.end_x - seg_in.start_x;
    dy = (seg_in.start_y > seg_in.end_y) ? seg_in.start_y - seg_in.end_y
                                         : seg_in.end_y - seg_in.start_y;
    off_grid = (int'(seg_in.start_x) >= GRID_SIDE) || (int'(seg_in.start_y) >= GRID_SIDE) ||
               (int'(seg_in.end_x) >= GRID_SIDE)   || (int'(seg_in.end_y) >= GRID_SIDE);
    axis = (dx == '0) || (dy == '0);
    diag = (dx == dy) && diag_en;

    cmd.skip = off_grid || !(axis || diag);
    if (axis) begin
      // walk upward from the lower end
      cmd.x     = (seg_in.start_x < seg_in.end_x) ? seg_in.start_x : seg_in.end_x;
      cmd.y     = (seg_in.start_y < seg_in.end_y) ? seg_in.start_y : seg_in.end_y;
      cmd.dir_x = (dx != '0) ? DIR_UP : DIR_HOLD;
      cmd.dir_y = (dy != '0) ? DIR_UP : DIR_HOLD;
      cmd.span  = dx + dy;
    end else begin
      cmd.x     = seg_in.start_x;
      cmd.y     = seg_in.start_y;
      cmd.dir_x = (seg_in.end_x > seg_in.start_x) ? DIR_UP : DIR_DOWN;
      cmd.dir_y = (seg_in.end_y > seg_in.start_y) ? DIR_UP : DIR_DOWN;
      cmd.span  = dx;
    end
  end

endmodule

// ----- rtl/sroc_queue.sv -----
`timescale 1ns / 1ps

module sroc_queue import sroc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  walk_cmd_t push_cmd,
  input  logic      pop,
  output walk_cmd_t head,
  output logic      full,
  output logic      empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  walk_cmd_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;

  assign full  = (fill == CW'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/sroc_back.sv -----
`timescale 1ns / 1ps

module sroc_back import sroc_pkg::*; #(
  parameter int GRID_SIDE = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  walk_cmd_t  q_head,
  input  logic       q_empty,
  output logic       pop,
  output logic       clearing,
  sroc_out_if.source res_out
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STEP = AW'(GRID_SIDE);
  localparam logic [AW-1:0] COL_STEP = AW'(1);
  localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);

  back_state_t state, state_next;

  logic [HITS_W-1:0]  mem [DEPTH];
  logic [HITS_W-1:0]  rd_data;
  logic               rd_en;
  logic               rd_pend;
  logic [AW-1:0]      rd_addr_q;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [HITS_W-1:0]  wr_data;

  walk_cmd_t          cur;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      delta;
  logic [AW-1:0]      row_term;
  logic [AW-1:0]      col_term;
  logic [COORD_W-1:0] left;
  logic [AW-1:0]      clr_addr;
  logic [TALLY_W-1:0] tally;
  logic               res_vld;
  logic [TALLY_W-1:0] res_total;
  logic               res_skip;
  logic               res_load;

  assign clearing = (state == B_CLEAR);

  // grid store: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // write-back of the cell read in the cycle before, or the clearing sweep
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = rd_pend && (rd_data != HIT_LIMIT);
      wr_addr = rd_addr_q;
      wr_data = rd_data + HITS_W'(1);
    end
  end

  always_comb begin
    unique case (cur.dir_x)
      DIR_UP:   row_term = ROW_STEP;
      DIR_DOWN: row_term = '0 - ROW_STEP;
      default:  row_term = '0;
    endcase
    unique case (cur.dir_y)
      DIR_UP:   col_term = COL_STEP;
      DIR_DOWN: col_term = '0 - COL_STEP;
      default:  col_term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      B_CLEAR: begin
        if (clr_addr == LAST) state_next = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = q_head.skip ? B_REPORT : B_LOAD;
        end
      end
      B_LOAD: begin
        state_next = B_WALK;
      end
      B_WALK: begin
        rd_en = 1'b1;
        if (left == '0) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        state_next = B_REPORT;
      end
      B_REPORT: begin
        if (!res_vld || res_out.ready) begin
          res_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (state == B_LOAD) begin
      addr  <= AW'(int'(cur.x) * GRID_SIDE + int'(cur.y));
      delta <= row_term + col_term;
      left  <= cur.span;
    end else if (state == B_WALK) begin
      addr <= addr + delta;
      left <= left - COORD_W'(1);
    end
    rd_addr_q <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      tally    <= '0;
      res_vld  <= 1'b0;
    end else begin
      if (clearing) clr_addr <= clr_addr + AW'(1);
      rd_pend <= rd_en;
      // cell going from one hit to two
      if (rd_pend && (rd_data == HIT_LIMIT - HITS_W'(1)) && (tally != TALLY_MAX)) begin
        tally <= tally + TALLY_W'(1);
      end
      if (res_load) begin
        res_vld <= 1'b1;
      end else if (res_out.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_total <= tally;
      res_skip  <= cur.skip;
    end
  end

  assign res_out.valid           = res_vld;
  assign res_out.overlap_total   = res_total;
  assign res_out.segment_skipped = res_skip;

endmodule
